@@ rtl/llbh_pkg.sv @@
`default_nettype none
package llbh_pkg;

  localparam int unsigned IdW = 4;
  localparam int unsigned IdCount = 16;
  localparam int unsigned CntW = 5;
  localparam int unsigned LoadW = 16;
  localparam int unsigned RndW = 32;
  localparam int unsigned RandomBits = 31;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_ACQUIRE = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_QUORUM = 2'd1,
    ST_BUSY   = 2'd2,
    ST_ERROR  = 2'd3
  } status_e;

  typedef enum logic {
    REG_QUORUM = 1'b0,
    REG_LIMIT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_KEY, S_UP, S_DL, S_DR, S_DMOV, S_FINAL, S_RESP
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CHECK, OP_KEY, OP_UP, OP_DL, OP_DR, OP_DMOV, OP_FINAL
  } dp_op_e;

  typedef struct packed {
    logic chk_sift;
    logic up_done;
    logic may;
    logic dl_none;
    logic dl_right;
    logic mv_stop;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/llbh_if.sv @@
`default_nettype none
interface llbh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] entry_id;
  logic [31:0] fresh_random;
  modport source (output valid, command, entry_id, fresh_random, input ready);
  modport sink (input valid, command, entry_id, fresh_random, output ready);
endinterface

interface llbh_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] chosen_id;
  logic [4:0] active_count;
  modport source (output valid, status, chosen_id, active_count, input ready);
  modport sink (input valid, status, chosen_id, active_count, output ready);
endinterface
`default_nettype wire

@@ rtl/llbh_ctrl.sv @@
`default_nettype none
module llbh_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  input  llbh_pkg::dp_stat_t     stat_i,
  output llbh_pkg::dp_op_e       op_o
);

  llbh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llbh_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    op_o        = llbh_pkg::OP_NONE;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      llbh_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = llbh_pkg::OP_LOAD;
          state_d = llbh_pkg::S_CHECK;
        end
      end
      llbh_pkg::S_CHECK: begin
        op_o    = llbh_pkg::OP_CHECK;
        state_d = stat_i.chk_sift ? llbh_pkg::S_KEY : llbh_pkg::S_RESP;
      end
      llbh_pkg::S_KEY: begin
        op_o    = llbh_pkg::OP_KEY;
        state_d = llbh_pkg::S_UP;
      end
      llbh_pkg::S_UP: begin
        op_o = llbh_pkg::OP_UP;
        if (stat_i.up_done) begin
          state_d = stat_i.may ? llbh_pkg::S_DL : llbh_pkg::S_FINAL;
        end
      end
      llbh_pkg::S_DL: begin
        op_o = llbh_pkg::OP_DL;
        if (stat_i.dl_none) begin
          state_d = llbh_pkg::S_FINAL;
        end else if (stat_i.dl_right) begin
          state_d = llbh_pkg::S_DR;
        end else begin
          state_d = llbh_pkg::S_DMOV;
        end
      end
      llbh_pkg::S_DR: begin
        op_o    = llbh_pkg::OP_DR;
        state_d = llbh_pkg::S_DMOV;
      end
      llbh_pkg::S_DMOV: begin
        op_o    = llbh_pkg::OP_DMOV;
        state_d = stat_i.mv_stop ? llbh_pkg::S_FINAL : llbh_pkg::S_DL;
      end
      llbh_pkg::S_FINAL: begin
        op_o    = llbh_pkg::OP_FINAL;
        state_d = llbh_pkg::S_RESP;
      end
      llbh_pkg::S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = llbh_pkg::S_IDLE;
        end
      end
      default: state_d = llbh_pkg::S_IDLE;
    endcase
  end

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while result pending");
  a_check_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == llbh_pkg::OP_LOAD |=> op_o == llbh_pkg::OP_CHECK)
    else $error("command not checked after accept");

endmodule
`default_nettype wire

@@ rtl/llbh_dp.sv @@
`default_nettype none
module llbh_dp #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  llbh_pkg::dp_op_e       op_i,
  input  wire  [1:0]             command_i,
  input  wire  [3:0]             entry_id_i,
  input  wire  [31:0]            fresh_random_i,
  input  wire                    cfg_we_i,
  input  wire                    cfg_idx_i,
  input  wire  [15:0]            cfg_data_i,
  output llbh_pkg::dp_stat_t     stat_o,
  output logic [1:0]             status_o,
  output logic [3:0]             chosen_id_o,
  output logic [4:0]             active_count_o
);

  localparam int unsigned Cap = (MAX_ENTRIES < llbh_pkg::IdCount) ? MAX_ENTRIES
                                                                   : llbh_pkg::IdCount;
  localparam int unsigned SW = $clog2(Cap + 1);
  localparam int unsigned Depth = 2 ** SW;

  llbh_pkg::cmd_e    cmd_q;
  logic [3:0]        id_q, cur_q, c_q, chosen_q;
  logic [31:0]       rnd_q, buf_q;
  logic [4:0]        pos_q, cnt_q, left_q, quorum_q;
  logic [5:0]        j_q;
  logic [15:0]       key_q, cl_q, limit_q;
  logic              may_q;
  llbh_pkg::status_e st_q;

  logic [3:0]  hs_q [Depth];
  logic [4:0]  so_q [llbh_pkg::IdCount];
  logic [15:0] ld_q [llbh_pkg::IdCount];

  logic [SW-1:0] hs_ra;
  logic [3:0]    hs_rd, ld_ra;
  logic [15:0]   ld_rd;
  logic [4:0]    so_rd;
  logic [5:0]    j2;
  llbh_pkg::status_e chk_st;
  logic          chk_ok, chk_sift, up_root, up_stop, eq, take, tbit;
  logic [31:0]   eff_buf;

  assign j2 = {pos_q, 1'b0};

  always_comb begin
    case (op_i)
      llbh_pkg::OP_CHECK: hs_ra = (cmd_q == llbh_pkg::CMD_ACQUIRE) ? SW'(1)
                                                                 : cnt_q[SW-1:0];
      llbh_pkg::OP_UP:    hs_ra = SW'(pos_q >> 1);
      llbh_pkg::OP_DL:    hs_ra = j2[SW-1:0];
      llbh_pkg::OP_DR:    hs_ra = j_q[SW-1:0] + SW'(1);
      default:            hs_ra = '0;
    endcase
  end
  assign hs_rd = hs_q[hs_ra];

  always_comb begin
    case (op_i)
      llbh_pkg::OP_CHECK: ld_ra = (cmd_q == llbh_pkg::CMD_ACQUIRE) ? hs_rd : id_q;
      llbh_pkg::OP_KEY:   ld_ra = cur_q;
      llbh_pkg::OP_UP,
      llbh_pkg::OP_DL,
      llbh_pkg::OP_DR:    ld_ra = hs_rd;
      default:            ld_ra = id_q;
    endcase
  end
  assign ld_rd = ld_q[ld_ra];
  assign so_rd = so_q[id_q];

  always_comb begin
    chk_st   = llbh_pkg::ST_OK;
    chk_sift = 1'b0;
    case (cmd_q)
      llbh_pkg::CMD_INSERT: begin
        if (so_rd != '0 || cnt_q >= 5'(Cap)) chk_st = llbh_pkg::ST_ERROR;
      end
      llbh_pkg::CMD_REMOVE: begin
        if (cnt_q == '0 || so_rd == '0) chk_st = llbh_pkg::ST_ERROR;
        else chk_sift = (hs_rd != id_q);
      end
      llbh_pkg::CMD_ACQUIRE: begin
        if (cnt_q < quorum_q) chk_st = llbh_pkg::ST_QUORUM;
        else if (cnt_q == '0) chk_st = llbh_pkg::ST_ERROR;
        else if (ld_rd >= limit_q) chk_st = llbh_pkg::ST_BUSY;
      end
      llbh_pkg::CMD_RELEASE: begin
        if (ld_rd == '0) chk_st = llbh_pkg::ST_ERROR;
        else chk_sift = (so_rd != '0);
      end
      default: chk_st = llbh_pkg::ST_ERROR;
    endcase
  end
  assign chk_ok = (chk_st == llbh_pkg::ST_OK);

  assign up_root = (pos_q <= 5'd1);
  assign up_stop = (ld_rd <= key_q);
  assign eff_buf = (left_q == '0) ? rnd_q : buf_q;
  assign tbit    = eff_buf[0];
  assign eq      = (ld_rd == cl_q);
  assign take    = (ld_rd < cl_q) || (eq && tbit);

  always_comb begin
    stat_o.chk_sift = chk_ok && (chk_sift || cmd_q == llbh_pkg::CMD_INSERT ||
                                 cmd_q == llbh_pkg::CMD_ACQUIRE);
    stat_o.up_done  = up_root || up_stop;
    stat_o.may      = may_q;
    stat_o.dl_none  = j2 > {1'b0, cnt_q};
    stat_o.dl_right = j2 < {1'b0, cnt_q};
    stat_o.mv_stop  = key_q <= cl_q;
  end

  // control and config state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      left_q   <= '0;
      buf_q    <= '0;
      quorum_q <= 5'd1;
      limit_q  <= 16'd1;
      for (int i = 0; i < llbh_pkg::IdCount; i++) begin
        so_q[i] <= '0;
        ld_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == llbh_pkg::REG_QUORUM) quorum_q <= cfg_data_i[4:0];
        else limit_q <= cfg_data_i;
      end
      case (op_i)
        llbh_pkg::OP_CHECK: begin
          if (chk_ok) begin
            case (cmd_q)
              llbh_pkg::CMD_INSERT:  cnt_q <= cnt_q + 5'd1;
              llbh_pkg::CMD_REMOVE: begin
                cnt_q       <= cnt_q - 5'd1;
                so_q[id_q]  <= '0;
              end
              llbh_pkg::CMD_ACQUIRE: ld_q[hs_rd] <= ld_rd + 16'd1;
              llbh_pkg::CMD_RELEASE: ld_q[id_q] <= ld_rd - 16'd1;
              default: ;
            endcase
          end
        end
        llbh_pkg::OP_UP: begin
          if (!up_root && !up_stop) so_q[hs_rd] <= pos_q;
        end
        llbh_pkg::OP_DR: begin
          if (eq) begin
            buf_q  <= eff_buf >> 1;
            left_q <= ((left_q == '0) ? 5'(llbh_pkg::RandomBits) : left_q) - 5'd1;
          end
        end
        llbh_pkg::OP_DMOV: begin
          if (!(key_q <= cl_q)) so_q[c_q] <= pos_q;
        end
        llbh_pkg::OP_FINAL: so_q[cur_q] <= pos_q;
        default: ;
      endcase
    end
  end

  // working registers and heap slots
  always_ff @(posedge clk_i) begin
    case (op_i)
      llbh_pkg::OP_LOAD: begin
        cmd_q <= llbh_pkg::cmd_e'(command_i);
        id_q  <= entry_id_i;
        rnd_q <= fresh_random_i;
      end
      llbh_pkg::OP_CHECK: begin
        st_q     <= chk_st;
        chosen_q <= (chk_ok && cmd_q == llbh_pkg::CMD_ACQUIRE) ? hs_rd : '0;
        may_q    <= (cmd_q != llbh_pkg::CMD_INSERT);
        case (cmd_q)
          llbh_pkg::CMD_INSERT: begin
            cur_q <= id_q;
            pos_q <= cnt_q + 5'd1;
          end
          llbh_pkg::CMD_REMOVE: begin
            cur_q <= hs_rd;
            pos_q <= so_rd;
          end
          llbh_pkg::CMD_ACQUIRE: begin
            cur_q <= hs_rd;
            pos_q <= 5'd1;
          end
          default: begin
            cur_q <= id_q;
            pos_q <= so_rd;
          end
        endcase
      end
      llbh_pkg::OP_KEY: key_q <= ld_rd;
      llbh_pkg::OP_UP: begin
        if (!up_root && !up_stop) begin
          hs_q[pos_q[SW-1:0]] <= hs_rd;
          may_q <= 1'b0;
          pos_q <= pos_q >> 1;
        end
      end
      llbh_pkg::OP_DL: begin
        c_q  <= hs_rd;
        cl_q <= ld_rd;
        j_q  <= j2;
      end
      llbh_pkg::OP_DR: begin
        if (take) begin
          c_q  <= hs_rd;
          cl_q <= ld_rd;
          j_q  <= j_q + 6'd1;
        end
      end
      llbh_pkg::OP_DMOV: begin
        if (!(key_q <= cl_q)) begin
          hs_q[pos_q[SW-1:0]] <= c_q;
          pos_q <= j_q[4:0];
        end
      end
      llbh_pkg::OP_FINAL: hs_q[pos_q[SW-1:0]] <= cur_q;
      default: ;
    endcase
  end

  assign status_o       = st_q;
  assign chosen_id_o    = chosen_q;
  assign active_count_o = cnt_q;

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(Cap))
    else $error("heap count beyond capacity");
  a_err_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == llbh_pkg::OP_CHECK && !chk_ok |=> $stable(cnt_q))
    else $error("refused command changed heap count");
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= 5'(llbh_pkg::RandomBits))
    else $error("tie-break bit count out of range");

endmodule
`default_nettype wire

@@ rtl/least_loaded_backend_heap.sv @@
`default_nettype none
// Least-loaded backend selector over an indexed binary min-heap keyed by per-entry
// load. One command is in flight at a time; input ready is high only when idle and
// the result holds on the output until taken. A command that needs no sift passes
// through accept, check and reply; any other passes through accept, check, key read,
// an upward compare per level moved up plus the last compare, then a downward sift
// when allowed (left child read, right child read when there is one, move, per level
// until it stops), final write and reply. The heap, position and load tables each
// give one read per cycle. Ties between children are broken by a 31-bit buffer
// refilled from fresh_random when empty.
module least_loaded_backend_heap #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  llbh_in_if.sink      in_i,
  llbh_out_if.source   out_o,
  input  wire          cfg_we_i,
  input  wire          cfg_idx_i,
  input  wire  [15:0]  cfg_data_i
);

  llbh_pkg::dp_stat_t stat;
  llbh_pkg::dp_op_e   op;

  llbh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .op_o        (op)
  );

  llbh_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .command_i      (in_i.command),
    .entry_id_i     (in_i.entry_id),
    .fresh_random_i (in_i.fresh_random),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .stat_o         (stat),
    .status_o       (out_o.status),
    .chosen_id_o    (out_o.chosen_id),
    .active_count_o (out_o.active_count)
  );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    llbh_pkg::cmd_e cmd;
    logic [3:0]     id;
    logic [31:0]    rnd;
  } command_t;

  typedef struct packed {
    llbh_pkg::status_e status;
    logic [3:0]        chosen;
    logic [4:0]        count;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  llbh_pkg::cfg_reg_e cfg_idx_i = llbh_pkg::REG_QUORUM;
  logic [15:0] cfg_data_i = '0;

  llbh_in_if  cmd_ch ();
  llbh_out_if reply_ch ();

  least_loaded_backend_heap #(.MAX_ENTRIES(16)) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (cmd_ch.sink),
    .out_o     (reply_ch.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow of the selector state
  int unsigned quorum_q = 1;
  int unsigned limit_q = 1;
  int unsigned slot_q[17];
  int unsigned pos_q[16];
  int unsigned load_q[16];
  int unsigned count_q = 0;
  int unsigned rbuf_q = 0;
  int unsigned rleft_q = 0;
  int unsigned fresh_q = 0;

  command_t pending_cmds[$];
  reply_t   expected_replies[$];
  int       errors = 0;
  bit       cmd_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       max_gap = 10;
  int       stall_mode = 0;
  int unsigned cycle_n = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("** least_loaded_backend_heap: FAILED **");
    $finish;
  end

  function automatic bit tie_bit();
    bit b;
    if (rleft_q == 0) begin
      rbuf_q = fresh_q;
      rleft_q = 31;
    end
    b = rbuf_q[0];
    rbuf_q = rbuf_q >> 1;
    rleft_q--;
    return b;
  endfunction

  function automatic void place(int unsigned pos, int unsigned id);
    slot_q[pos] = id;
    pos_q[id] = pos;
  endfunction

  function automatic void heap_sift(int unsigned id, int unsigned pos, bit may);
    int unsigned key, j, p, c, c2;
    key = load_q[id];
    while (pos > 1) begin
      j = pos / 2;
      p = slot_q[j];
      if (load_q[p] <= key) break;
      place(pos, p);
      may = 1'b0;
      pos = j;
    end
    if (may) begin
      while (pos * 2 <= count_q) begin
        j = pos * 2;
        c = slot_q[j];
        if (j < count_q) begin
          c2 = slot_q[j + 1];
          if (load_q[c2] < load_q[c] || (load_q[c2] == load_q[c] && tie_bit())) begin
            j++;
            c = c2;
          end
        end
        if (key <= load_q[c]) break;
        place(pos, c);
        pos = j;
      end
    end
    place(pos, id);
  endfunction

  function automatic reply_t predict_reply(command_t c);
    reply_t r;
    int unsigned head, last, pos;
    r.status = llbh_pkg::ST_OK;
    r.chosen = '0;
    fresh_q = c.rnd;
    case (c.cmd)
      llbh_pkg::CMD_INSERT: begin
        if (pos_q[c.id] != 0 || count_q >= 16) r.status = llbh_pkg::ST_ERROR;
        else begin
          count_q++;
          heap_sift(c.id, count_q, 1'b0);
        end
      end
      llbh_pkg::CMD_REMOVE: begin
        pos = pos_q[c.id];
        if (count_q == 0 || pos == 0) r.status = llbh_pkg::ST_ERROR;
        else begin
          last = slot_q[count_q];
          count_q--;
          if (last != c.id) heap_sift(last, pos, 1'b1);
          pos_q[c.id] = 0;
        end
      end
      llbh_pkg::CMD_ACQUIRE: begin
        if (count_q < quorum_q) r.status = llbh_pkg::ST_QUORUM;
        else if (count_q == 0) r.status = llbh_pkg::ST_ERROR;
        else begin
          head = slot_q[1];
          if (load_q[head] >= limit_q) r.status = llbh_pkg::ST_BUSY;
          else begin
            load_q[head] = (load_q[head] + 1) & 16'hFFFF;
            heap_sift(head, 1, 1'b1);
            r.chosen = 4'(head);
          end
        end
      end
      default: begin
        if (load_q[c.id] == 0) r.status = llbh_pkg::ST_ERROR;
        else begin
          load_q[c.id]--;
          if (pos_q[c.id] != 0) heap_sift(c.id, pos_q[c.id], 1'b1);
        end
      end
    endcase
    r.count = 5'(count_q);
    return r;
  endfunction

  // Accept side: predict on every command beat, check every reply beat
  always @(posedge clk_i) begin
    reply_t want;
    cycle_n++;
    if (rst_ni && cmd_ch.valid && cmd_ch.ready) begin
      expected_replies.push_back(predict_reply({llbh_pkg::cmd_e'(cmd_ch.command),
                                                cmd_ch.entry_id, cmd_ch.fresh_random}));
      cmd_taken = 1'b1;
    end
    if (rst_ni && reply_ch.valid && reply_ch.ready) begin
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply status=%0d id=%0d count=%0d", $time,
                 reply_ch.status, reply_ch.chosen_id, reply_ch.active_count);
      end else begin
        want = expected_replies.pop_front();
        if (reply_ch.status !== want.status || reply_ch.chosen_id !== want.chosen ||
            reply_ch.active_count !== want.count) begin
          errors++;
          $display("%0t: reply mismatch expected status=%0d id=%0d count=%0d, got %0d %0d %0d",
                   $time, want.status, want.chosen, want.count, reply_ch.status,
                   reply_ch.chosen_id, reply_ch.active_count);
        end
      end
    end
  end

  // Command driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (cmd_taken || !cmd_ch.valid) begin
      cmd_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        cmd_ch.valid <= 1'b0;
      end else if (pending_cmds.size() == 0 || !rst_ni) begin
        cmd_ch.valid <= 1'b0;
      end else begin
        command_t c;
        c = pending_cmds.pop_front();
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= c.cmd;
        cmd_ch.entry_id <= c.id;
        cmd_ch.fresh_random <= c.rnd;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(1, 12);
          gap_left = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        end
      end
    end
  end

  // Reply stall pattern
  always @(negedge clk_i) begin
    case (stall_mode)
      0: reply_ch.ready <= 1'b1;
      1: reply_ch.ready <= 1'($urandom_range(0, 1));
      default: reply_ch.ready <= (cycle_n % 7) > 2;
    endcase
  end

  task automatic write_reg(llbh_pkg::cfg_reg_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    if (idx == llbh_pkg::REG_QUORUM) quorum_q = int'(data[4:0]);
    else limit_q = int'(data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic add_cmd(llbh_pkg::cmd_e cmd, int unsigned id);
    pending_cmds.push_back({cmd, id[3:0], $urandom()});
  endtask

  task automatic add_random(int n);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) add_cmd(llbh_pkg::CMD_INSERT, $urandom_range(0, 15));
      else if (roll < 38) add_cmd(llbh_pkg::CMD_REMOVE, $urandom_range(0, 15));
      else if (roll < 78) add_cmd(llbh_pkg::CMD_ACQUIRE, $urandom_range(0, 15));
      else add_cmd(llbh_pkg::CMD_RELEASE, $urandom_range(0, 15));
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_replies.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic run_phase(int q, int l, int gap, int mode, int n);
    write_reg(llbh_pkg::REG_QUORUM, 16'(q));
    write_reg(llbh_pkg::REG_LIMIT, 16'(l));
    max_gap = gap;
    stall_mode = mode;
    add_random(n);
    drain();
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.command = llbh_pkg::CMD_INSERT;
    cmd_ch.entry_id = '0;
    cmd_ch.fresh_random = '0;
    reply_ch.ready = 1'b0;
    foreach (slot_q[i]) slot_q[i] = 0;
    foreach (pos_q[i]) begin
      pos_q[i] = 0;
      load_q[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: errors, refusals, absent release, grants at the reset limit
    add_cmd(llbh_pkg::CMD_RELEASE, 5);
    add_cmd(llbh_pkg::CMD_ACQUIRE, 0);
    add_cmd(llbh_pkg::CMD_REMOVE, 3);
    add_cmd(llbh_pkg::CMD_INSERT, 0);
    add_cmd(llbh_pkg::CMD_INSERT, 15);
    add_cmd(llbh_pkg::CMD_INSERT, 0);
    add_cmd(llbh_pkg::CMD_ACQUIRE, 9);
    add_cmd(llbh_pkg::CMD_ACQUIRE, 0);
    add_cmd(llbh_pkg::CMD_ACQUIRE, 0);
    add_cmd(llbh_pkg::CMD_RELEASE, 0);
    add_cmd(llbh_pkg::CMD_REMOVE, 15);
    add_cmd(llbh_pkg::CMD_RELEASE, 15);
    add_cmd(llbh_pkg::CMD_REMOVE, 15);
    add_cmd(llbh_pkg::CMD_REMOVE, 0);
    drain();

    // Quorum zero on an empty heap, then fill it and overfill
    write_reg(llbh_pkg::REG_QUORUM, 16'd0);
    write_reg(llbh_pkg::REG_LIMIT, 16'hFFFF);
    add_cmd(llbh_pkg::CMD_ACQUIRE, 0);
    for (int i = 0; i < 16; i++) add_cmd(llbh_pkg::CMD_INSERT, i);
    add_cmd(llbh_pkg::CMD_INSERT, 7);
    repeat (6) add_cmd(llbh_pkg::CMD_ACQUIRE, 0);
    drain();

    run_phase(0, 16'hFFFF, 0, 0, 300);
    run_phase(16, 4, 10, 1, 300);
    run_phase(3, 2, 4, 2, 300);
    run_phase(1, 1, 15, 1, 300);
    run_phase($urandom_range(0, 16), $urandom_range(1, 65535), 6, 2, 300);
    run_phase(2, 8, 0, 1, 300);

    if (errors == 0) $display("** least_loaded_backend_heap: PASSED **");
    else $display("** least_loaded_backend_heap: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
